@@ rtl/cs_pkg.sv @@
package cs_pkg;

   // Fixed widths of the channel fields and the configuration port.
   localparam int FIELD_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 1;

   // Register map.
   localparam logic [CSR_ADDR_W-1:0] ADDR_GREY_MAX = 1'b0;

   localparam logic [FIELD_W-1:0] GREY_MAX_RESET = 16'd255;

   // The quotient never exceeds grey_max, so one divider step per result bit.
   localparam int QUO_BITS = FIELD_W;
   localparam int CNT_W    = $clog2(QUO_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_BITS - 1);

   // Pass codes carried by the kind field.
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_STRETCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } cs_state_type;

   typedef struct packed {
      logic load_meas;
      logic load_str;
      logic mul;
      logic div_step;
      logic out_load;
   } cs_cmd_type;

   typedef struct packed {
      logic out_free;
   } cs_stat_type;

endpackage

@@ rtl/cs_ifs.sv @@
interface cs_req_if
   import cs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [FIELD_W-1:0] pixel;
   logic               first;
   logic               last;

   modport source (output valid, output kind, output pixel, output first, output last,
                   input ready);
   modport sink   (input valid, input kind, input pixel, input first, input last,
                   output ready);
endinterface

interface cs_rsp_if
   import cs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] stretched;
   logic               end_of_image;

   modport source (output valid, output stretched, output end_of_image, input ready);
   modport sink   (input valid, input stretched, input end_of_image, output ready);
endinterface

@@ rtl/cs_ctrl.sv @@
module cs_ctrl
   import cs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_kind,
   output logic        req_ready,
   input  cs_stat_type stat,
   output cs_cmd_type  cmd
);

   cs_state_type     state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The step counter only runs while dividing and rests at zero otherwise.
   assign cnt_in = (state_ff == ST_DIV) ? cnt_ff + CNT_W'(1) : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_STRETCH) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_meas = req_valid && req_kind == KIND_MEASURE;
            cmd.load_str  = req_valid && req_kind == KIND_STRETCH;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/cs_dp.sv @@
module cs_dp
   import cs_pkg::*;
#(
   parameter int PIXEL_BITS = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  cs_cmd_type         cmd,
   output cs_stat_type        stat,
   input  logic [FIELD_W-1:0] req_pixel,
   input  logic               req_first,
   input  logic               req_last,
   input  logic [FIELD_W-1:0] grey_max,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [FIELD_W-1:0] rsp_stretched,
   output logic               rsp_end_of_image
);

   localparam int PROD_W = PIXEL_BITS + FIELD_W;

   logic [PIXEL_BITS-1:0] low_ff, low_in;
   logic [PIXEL_BITS-1:0] high_ff, high_in;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic                  last_ff;
   logic                  zero_ff, sat_ff;
   logic [PIXEL_BITS-1:0] span_ff;
   logic [PIXEL_BITS-1:0] rem_ff;
   logic [FIELD_W-1:0]    quo_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [FIELD_W-1:0]    out_data_ff;
   logic                  out_last_ff;

   logic [PIXEL_BITS-1:0] req_pix;
   logic [PIXEL_BITS-1:0] diff;
   logic [PROD_W-1:0]     prod;
   logic [PIXEL_BITS:0]   trial;
   logic [PIXEL_BITS:0]   trial_sub;
   logic                  qbit;
   logic [FIELD_W-1:0]    result;

   assign req_pix = req_pixel[PIXEL_BITS-1:0];

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.load_meas) begin
         if (req_first) begin
            low_in  = req_pix;
            high_in = req_pix;
         end else begin
            if (req_pix < low_ff)  low_in  = req_pix;
            if (req_pix > high_ff) high_in = req_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '1;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_str) begin
         pix_ff  <= req_pix;
         last_ff <= req_last;
      end
   end

   // The remainder starts as the upper part of the product, which is below the
   // span, so sixteen restoring steps yield the whole quotient.
   assign diff      = pix_ff - low_ff;
   assign prod      = PROD_W'(diff) * PROD_W'(grey_max);
   assign trial     = {rem_ff, quo_ff[FIELD_W-1]};
   assign trial_sub = trial - {1'b0, span_ff};
   assign qbit      = trial >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         zero_ff <= (high_ff <= low_ff) || (pix_ff < low_ff);
         sat_ff  <= pix_ff > high_ff;
         span_ff <= high_ff - low_ff;
         rem_ff  <= prod[PROD_W-1:FIELD_W];
         quo_ff  <= prod[FIELD_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff  <= qbit ? trial_sub[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
         quo_ff  <= {quo_ff[FIELD_W-2:0], qbit};
      end
   end

   always_comb begin
      if (zero_ff)     result = '0;
      else if (sat_ff) result = grey_max;
      else             result = quo_ff;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load)   out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= result;
         out_last_ff <= last_ff;
      end
   end

   assign stat.out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid        = out_valid_ff;
   assign rsp_stretched    = out_data_ff;
   assign rsp_end_of_image = out_last_ff;

endmodule

@@ rtl/contrast_stretch.sv @@
// Linear min-max contrast stretch of grey pixels.
// Every image is sent twice on the request channel. Items with kind low form
// the measuring pass: each one updates the running minimum and maximum, and an
// item with first set restarts both from its own pixel. Measuring items produce
// no result and are taken whenever the controller is idle. Items with kind
// high form the stretching pass: each one produces exactly one result item on
// the response channel, floor((pixel - min) * grey_max / (max - min)), 0 below
// the minimum, grey_max above the maximum, and 0 when no range has been
// measured or the image is flat. A stretching item passes the multiply state,
// sixteen steps of the restoring divider (one quotient bit per cycle) and the
// output load before its result is shown. The controller returns to idle at
// that load and only then takes the next item, so no new item is taken before
// the previous stretch is loaded. The output register holds the result while
// the receiver stalls; the block keeps taking measuring items meanwhile and
// finishes the next stretch, then waits for the register to drain. grey_max
// sits at address 0 of the configuration port. Reset sets grey_max to 255,
// clears the output valid and puts the minimum at full scale and the maximum
// at zero.
module contrast_stretch
   import cs_pkg::*;
#(
   parameter int PIXEL_BITS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   cs_req_if.sink                req_if,
   cs_rsp_if.source              rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cs_cmd_type         cmd;
   cs_stat_type        stat;
   logic [FIELD_W-1:0] grey_max_ff, grey_max_in;
   logic               csr_write;

   // The configuration port never stalls; a write lands at the access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      grey_max_in = grey_max_ff;
      if (csr_write && paddr == ADDR_GREY_MAX) grey_max_in = pwdata[FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grey_max_ff <= GREY_MAX_RESET;
      end else begin
         grey_max_ff <= grey_max_in;
      end
   end

   // Reads of the unused address return zero.
   assign prdata = (paddr == ADDR_GREY_MAX) ? CSR_DATA_W'(grey_max_ff) : '0;

   // The controller sequences capture, multiply, divide and output load.
   cs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the running range, the divider and the output register.
   cs_dp #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_pixel        (req_if.pixel),
      .req_first        (req_if.first),
      .req_last         (req_if.last),
      .grey_max         (grey_max_ff),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_stretched    (rsp_if.stretched),
      .rsp_end_of_image (rsp_if.end_of_image)
   );

endmodule

@@ tb/contrast_stretch_tb.sv @@
module contrast_stretch_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cs_pkg::*;

   // Clock, reset and pacing of the bench.
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 8;
   // Quiet cycles after the last result, enough for the block to be idle again.
   localparam int SETTLE_CYCLES = 24;
   // Cycles with no transfer on any port before the run is declared hung.
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1500;

   // Address 1 holds no register, so writes there must change nothing.
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = ~ADDR_GREY_MAX;
   localparam logic [FIELD_W-1:0] GREY_MAX_EXTREMES [3] = '{16'd0, 16'd1, 16'hFFFF};

   // How the result receiver throttles the block.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // One expected result item, in the layout of the response channel.
   typedef struct packed {
      logic [FIELD_W-1:0] stretched;
      logic               end_of_image;
   } stretch_result_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cs_req_if req_bus ();
   cs_rsp_if rsp_bus ();

   // Predicted state of the block: the output scale and the measured range.
   logic [FIELD_W-1:0] grey_max_q;
   logic [FIELD_W-1:0] min_level;
   logic [FIELD_W-1:0] max_level;

   // Results that the block still owes, oldest first.
   stretch_result_type pending_results [$];

   int  error_count      = 0;
   int  pixels_sent      = 0;
   int  measured_count   = 0;
   int  stretch_count    = 0;
   int  results_checked  = 0;
   int  grey_max_writes  = 0;
   int  burst_left       = 0;
   bit  gaps_enabled     = 1'b1;

   contrast_stretch i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // The receiver picks a new stall behavior whenever the current one runs out, so that
   // runs with no back-pressure alternate with light, regular and heavy stalls.
   // Ready is driven only here.
   initial begin : response_stalls
      stall_mode_type mode;
      int             mode_left;
      mode      = STALL_NONE;
      mode_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            STALL_NONE: begin
               rsp_bus.ready <= 1'b1;
            end
            STALL_LIGHT: begin
               rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            end
            STALL_PERIODIC: begin
               rsp_bus.ready <= (mode_left % 5 == 0);
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   // Every result taken by the receiver is matched against the oldest
   // prediction. Signals are read at the edge before any update lands, so the
   // values seen are the ones the block saw.
   always @(posedge clock) begin : check_results
      stretch_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            $error("result item with none expected: stretched %0d, end_of_image %0b",
                   rsp_bus.stretched, rsp_bus.end_of_image);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.stretched !== want.stretched) begin
               $error("stretched: expected %0d, actual %0d",
                      want.stretched, rsp_bus.stretched);
               error_count++;
            end
            if (rsp_bus.end_of_image !== want.end_of_image) begin
               $error("end_of_image: expected %0b, actual %0b",
                      want.end_of_image, rsp_bus.end_of_image);
               error_count++;
            end
         end
      end
   end

   // The run is hung if nothing moves on any port for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results.size());
            $display("contrast_stretch verification failed");
            $finish;
         end
      end
   end

   // Sends one pixel and updates the prediction once the block has taken it.
   // The sender works in bursts; at the start of each burst it may first leave
   // the channel idle. Valid is left high on return so the next item can follow
   // back to back.
   task automatic send_pixel(input logic kind, input logic [FIELD_W-1:0] pixel,
                             input logic is_first, input logic is_last);
      int                   gap;
      logic [2*FIELD_W-1:0] scaled;
      stretch_result_type   result;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = gaps_enabled ? $urandom_range(1, 10) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.pixel <= pixel;
      req_bus.first <= is_first;
      req_bus.last  <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;

      if (kind == KIND_MEASURE) begin
         // The measuring pass only moves the range; a first pixel restarts it.
         measured_count++;
         if (is_first) begin
            min_level = pixel;
            max_level = pixel;
         end else begin
            if (pixel < min_level) min_level = pixel;
            if (pixel > max_level) max_level = pixel;
         end
      end else begin
         // No range yet or a flat image gives zero, as does a pixel below the
         // minimum; above the maximum the output saturates at grey_max.
         result.end_of_image = is_last;
         if (max_level <= min_level || pixel < min_level) begin
            result.stretched = '0;
         end else if (pixel > max_level) begin
            result.stretched = grey_max_q;
         end else begin
            scaled           = (pixel - min_level) * grey_max_q;
            result.stretched = FIELD_W'(scaled / (max_level - min_level));
         end
         pending_results.push_back(result);
         stretch_count++;
      end
   endtask

   // Drops valid, waits for every owed result and then lets the block settle.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // One APB transfer: a setup phase, an access phase and an idle phase, so
   // that back-to-back transfers never touch psel twice in one time step.
   task automatic apb_transfer(input logic write_en, input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_grey_max();
      logic [CSR_DATA_W-1:0] readback;
      apb_transfer(1'b0, ADDR_GREY_MAX, '0, readback);
      if (readback[FIELD_W-1:0] !== grey_max_q) begin
         $error("grey_max: expected %0d, actual %0d", grey_max_q, readback[FIELD_W-1:0]);
         error_count++;
      end
   endtask

   // Writes a register with junk in the unused upper bits, then reads grey_max
   // back. Only the low 16 bits of a write to grey_max take effect.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [FIELD_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      apb_transfer(1'b1, addr, {(CSR_DATA_W-FIELD_W)'($urandom), value}, readback);
      if (addr == ADDR_GREY_MAX) begin
         grey_max_q = value;
         grey_max_writes++;
      end
      check_grey_max();
   endtask

   // A well-formed image: a measuring pass over pixels of one grey band, then
   // a stretching pass with most pixels inside the band and a few anywhere.
   // Without restart the measuring pass widens the range left from before.
   task automatic send_image(input int measure_len, input int stretch_len, input bit restart);
      int                 band_w;
      int                 band_lo;
      int                 band_hi;
      logic [FIELD_W-1:0] pixel;
      case ($urandom_range(0, 3))
         0: band_w = $urandom_range(0, 15);
         1: band_w = $urandom_range(16, 4095);
         2: band_w = $urandom_range(4096, 65535);
         default: band_w = 65535;
      endcase
      band_lo = $urandom_range(0, 65535 - band_w);
      band_hi = band_lo + band_w;
      for (int i = 0; i < measure_len; i++) begin
         send_pixel(KIND_MEASURE, FIELD_W'($urandom_range(band_lo, band_hi)),
                    restart && (i == 0), i == measure_len - 1);
      end
      for (int i = 0; i < stretch_len; i++) begin
         if ($urandom_range(0, 99) < 85) pixel = FIELD_W'($urandom_range(band_lo, band_hi));
         else pixel = FIELD_W'($urandom_range(0, 65535));
         send_pixel(KIND_STRETCH, pixel, 1'($urandom_range(0, 1)), i == stretch_len - 1);
      end
   endtask

   // Items with every field random: stray flags, passes cut short.
   task automatic send_noise(input int count);
      repeat (count) begin
         send_pixel(1'($urandom_range(0, 1)), FIELD_W'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Straight after reset nothing has been measured, so every stretched pixel
   // must come out as zero. A first flag in the stretching pass is ignored.
   task automatic test_unmeasured_range();
      check_grey_max();
      send_pixel(KIND_STRETCH, 16'd0, 1'b1, 1'b0);
      send_pixel(KIND_STRETCH, 16'hFFFF, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd40000, 1'b0, 1'b1);
   endtask

   // Range 1000..2000 under the reset scale: pixels on, inside and outside the
   // range. A last flag in the measuring pass gives no result. Then a flat
   // image, where even a pixel above the single level must give zero.
   task automatic test_range_edges();
      send_pixel(KIND_MEASURE, 16'd1000, 1'b1, 1'b0);
      send_pixel(KIND_MEASURE, 16'd2000, 1'b0, 1'b0);
      send_pixel(KIND_MEASURE, 16'd1500, 1'b0, 1'b1);
      send_pixel(KIND_STRETCH, 16'd999, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd1000, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd2000, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd2001, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd1500, 1'b0, 1'b1);
      send_pixel(KIND_MEASURE, 16'd100, 1'b1, 1'b1);
      send_pixel(KIND_STRETCH, 16'd99, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd100, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'd101, 1'b0, 1'b1);
   endtask

   // Full-scale range under grey_max of zero, one and full scale, then a write
   // to the unmapped address that must leave full scale in place.
   task automatic test_grey_max_settings();
      send_pixel(KIND_MEASURE, 16'd0, 1'b1, 1'b0);
      send_pixel(KIND_MEASURE, 16'hFFFF, 1'b0, 1'b1);
      foreach (GREY_MAX_EXTREMES[i]) begin
         wait_for_results();
         csr_write(ADDR_GREY_MAX, GREY_MAX_EXTREMES[i]);
         send_pixel(KIND_STRETCH, 16'd32768, 1'b0, 1'b0);
         send_pixel(KIND_STRETCH, 16'hFFFF, 1'b0, 1'b1);
      end
      wait_for_results();
      csr_write(ADDR_UNMAPPED, 16'h1234);
      send_pixel(KIND_STRETCH, 16'd32768, 1'b0, 1'b0);
      send_pixel(KIND_STRETCH, 16'hFFFF, 1'b0, 1'b1);
   endtask

   // Mostly whole images with random content, mixed with noise, images that
   // extend the previous range and full drains. At the start and after each
   // further 300 items the block is drained and given a new scale and sender pace.
   task automatic test_random_images();
      int stop_at;
      int next_retune;
      int pick;
      logic [FIELD_W-1:0] level;
      stop_at     = pixels_sent + RANDOM_ITEMS;
      next_retune = pixels_sent;
      while (pixels_sent < stop_at) begin
         if (pixels_sent >= next_retune) begin
            case ($urandom_range(0, 5))
               0: level = 16'd1;
               1: level = 16'hFFFF;
               2: level = GREY_MAX_RESET;
               3: level = 16'd0;
               default: level = FIELD_W'($urandom_range(1, 65535));
            endcase
            wait_for_results();
            csr_write(ADDR_GREY_MAX, level);
            gaps_enabled = ($urandom_range(0, 3) != 0);
            next_retune += 300;
         end
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            send_image($urandom_range(1, 24), $urandom_range(1, 24), 1'b1);
         end else if (pick < 88) begin
            send_noise($urandom_range(1, 8));
         end else if (pick < 96) begin
            send_image($urandom_range(1, 6), $urandom_range(1, 12), 1'b0);
         end else begin
            wait_for_results();
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.kind   <= KIND_MEASURE;
      req_bus.pixel  <= '0;
      req_bus.first  <= 1'b0;
      req_bus.last   <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= ADDR_GREY_MAX;
      pwdata         <= '0;
      grey_max_q      = GREY_MAX_RESET;
      min_level       = '1;
      max_level       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_unmeasured_range();
      test_range_edges();
      test_grey_max_settings();
      test_random_images();
      wait_for_results();

      $display("Sent %0d pixels (%0d measured, %0d stretched), checked %0d results.",
               pixels_sent, measured_count, stretch_count, results_checked);
      $display("Scale was rewritten %0d times, with zero, one and full scale among them.",
               grey_max_writes);
      if (error_count == 0) begin
         $display("contrast_stretch verification clean");
      end else begin
         $display("contrast_stretch verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/cs_pkg.sv
rtl/cs_ifs.sv
rtl/cs_ctrl.sv
rtl/cs_dp.sv
rtl/contrast_stretch.sv
tb/contrast_stretch_tb.sv
